FILE: rtl/sbc_pkg.sv
// ---------------------------------------------------------------------------
// Stack bytecode core package
// Opcodes, status codes and the control structures shared by the modules.
// ---------------------------------------------------------------------------
`default_nettype none
package sbc_pkg;

  localparam int unsigned CMD_W  = 6;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned PC_W   = 16;
  localparam int unsigned STAT_W = 3;

  typedef logic [CMD_W-1:0]  opcode_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam opcode_t OP_DUMMY   = 6'd0;
  localparam opcode_t OP_ENDL    = 6'd1;
  localparam opcode_t OP_ENDV    = 6'd2;
  localparam opcode_t OP_PUSHL   = 6'd3;
  localparam opcode_t OP_PUSHV   = 6'd4;
  localparam opcode_t OP_POP     = 6'd5;
  localparam opcode_t OP_XCHG    = 6'd6;
  localparam opcode_t OP_ADD     = 6'd7;
  localparam opcode_t OP_SUB     = 6'd8;
  localparam opcode_t OP_MUL     = 6'd9;
  localparam opcode_t OP_DIV     = 6'd10;
  localparam opcode_t OP_IDIV    = 6'd11;
  localparam opcode_t OP_MOD     = 6'd12;
  localparam opcode_t OP_IMOD    = 6'd13;
  localparam opcode_t OP_AND     = 6'd14;
  localparam opcode_t OP_OR      = 6'd15;
  localparam opcode_t OP_XOR     = 6'd16;
  localparam opcode_t OP_SHL     = 6'd17;
  localparam opcode_t OP_SHR     = 6'd18;
  localparam opcode_t OP_SAR     = 6'd19;
  localparam opcode_t OP_NEG     = 6'd20;
  localparam opcode_t OP_NOT     = 6'd21;
  localparam opcode_t OP_EQU     = 6'd22;
  localparam opcode_t OP_NEQ     = 6'd23;
  localparam opcode_t OP_LES     = 6'd24;
  localparam opcode_t OP_LEQ     = 6'd25;
  localparam opcode_t OP_GTR     = 6'd26;
  localparam opcode_t OP_GEQ     = 6'd27;
  localparam opcode_t OP_BEL     = 6'd28;
  localparam opcode_t OP_BEQ     = 6'd29;
  localparam opcode_t OP_ABV     = 6'd30;
  localparam opcode_t OP_AEQ     = 6'd31;
  localparam opcode_t OP_JMP     = 6'd32;
  localparam opcode_t OP_JZ      = 6'd33;
  localparam opcode_t OP_JNZ     = 6'd34;
  localparam opcode_t OP_CALL    = 6'd35;
  localparam opcode_t OP_RET     = 6'd36;
  localparam opcode_t OP_RETL    = 6'd37;
  localparam opcode_t OP_RETV    = 6'd38;
  localparam opcode_t OP_OPSIZE  = 6'd39;
  localparam opcode_t OP_INSSIZE = 6'd40;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_OVER    = 3'd1;
  localparam status_t ST_UNDER   = 3'd2;
  localparam status_t ST_DIVZ    = 3'd3;
  localparam status_t ST_ILLEGAL = 3'd4;

  localparam logic [WORD_W-1:0] OPERAND_BYTES = 64'd8;
  localparam logic [WORD_W-1:0] INSTR_BYTES   = 64'd16;

  // Multiply/divide unit operations.
  typedef enum logic [2:0] {
    MD_MUL, MD_DIVU, MD_DIVS, MD_MODU, MD_MODS
  } md_op_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic take;      // latch the instruction
    logic exec;      // commit a result computed without the multiply/divide unit
    logic md_start;  // launch the multiply/divide unit
    logic md_fin;    // commit the multiply/divide result
    logic load_out;  // move the result into the output register
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_read;
    logic is_md;
    logic md_done;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: rtl/sbc_in_if.sv
// ---------------------------------------------------------------------------
// Instruction channel
// Valid/ready channel carrying one instruction per transfer.
// ---------------------------------------------------------------------------
`default_nettype none
interface sbc_in_if;
  logic                              valid;
  logic                              ready;
  logic [sbc_pkg::CMD_W-1:0]         cmd;
  logic [sbc_pkg::WORD_W-1:0]        arg;
  logic [sbc_pkg::PC_W-1:0]          pc;

  modport source (output valid, cmd, arg, pc, input ready);
  modport sink   (input valid, cmd, arg, pc, output ready);
endinterface
`default_nettype wire

FILE: rtl/sbc_out_if.sv
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result per transfer.
// ---------------------------------------------------------------------------
`default_nettype none
interface sbc_out_if;
  logic                              valid;
  logic                              ready;
  logic [sbc_pkg::PC_W-1:0]          next_pc;
  logic                              done_res;
  logic [sbc_pkg::WORD_W-1:0]        value;
  logic [sbc_pkg::STAT_W-1:0]        status;

  modport source (output valid, next_pc, done_res, value, status, input ready);
  modport sink   (input valid, next_pc, done_res, value, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/stack_bytecode_core_unit.sv
// ---------------------------------------------------------------------------
// Stack bytecode core
// Executes one integer stack-machine instruction per transfer and returns
// one result per instruction.
// ---------------------------------------------------------------------------
// An instruction that needs no stack memory read passes the decode and finish
// states; one that reads the stack memory (registered RAM read) also passes the
// execute state, and MUL, DIV, IDIV, MOD and IMOD then wait for a
// shared shift-add/restoring unit that retires one bit per cycle. The core
// holds one instruction at a time; the next is accepted once the previous
// result sits in the output register, which may still be waiting to be taken.
// The top of stack lives in a register and deeper entries in a STACK_DEPTH
// word RAM, which needs no clearing after reset.
`default_nettype none
module stack_bytecode_core_unit #(
  parameter int unsigned STACK_DEPTH = 1024,
  parameter int unsigned PC_BITS     = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  sbc_in_if.sink   in_ch,
  sbc_out_if.source out_ch
);

  sbc_pkg::dp_cmd_t cmd;
  sbc_pkg::dp_sts_t sts;
  logic             in_ready;
  logic             out_valid;

  // Controller.
  sbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath.
  sbc_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .PC_BITS     (PC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_cmd       (in_ch.cmd),
    .in_arg       (in_ch.arg),
    .in_pc        (in_ch.pc),
    .out_next_pc  (out_ch.next_pc),
    .out_done_res (out_ch.done_res),
    .out_value    (out_ch.value),
    .out_status   (out_ch.status)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule
`default_nettype wire

FILE: rtl/sbc_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module sbc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/sbc_muldiv.sv
// ---------------------------------------------------------------------------
// Multiply/divide unit
// Shift-add multiplier and restoring divider, one bit per cycle over 64
// bits. Signed division works on magnitudes and fixes the signs at the end.
// ---------------------------------------------------------------------------
`default_nettype none
module sbc_muldiv (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire sbc_pkg::md_op_t            op,
  input  wire logic [sbc_pkg::WORD_W-1:0] lhs,
  input  wire logic [sbc_pkg::WORD_W-1:0] rhs,
  output logic                            done,
  output logic      [sbc_pkg::WORD_W-1:0] result
);

  localparam int unsigned W = sbc_pkg::WORD_W;

  logic                 busy_r;
  logic                 done_r;
  logic [6:0]           cnt_r;
  sbc_pkg::md_op_t      op_r;
  logic                 neg_r;
  logic [W:0]           rem_r;
  logic [W-1:0]         a_r;
  logic [W-1:0]         b_r;
  logic [W-1:0]         q_r;
  logic [W-1:0]         lhs_mag;
  logic [W-1:0]         rhs_mag;
  logic                 is_signed;
  logic [W:0]           shifted;
  logic [W+1:0]         diff;
  logic                 ge;

  assign is_signed = (op == sbc_pkg::MD_DIVS) || (op == sbc_pkg::MD_MODS);
  assign lhs_mag   = (is_signed && lhs[W-1]) ? (~lhs + 1'b1) : lhs;
  assign rhs_mag   = (is_signed && rhs[W-1]) ? (~rhs + 1'b1) : rhs;

  // One restoring division step.
  assign shifted = {rem_r[W-1:0], q_r[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, b_r};
  assign ge      = !diff[W+1];

  // Control: count iterations and flag completion.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd63;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      op_r  <= op;
      rem_r <= '0;
      if (op == sbc_pkg::MD_MUL) begin
        a_r   <= lhs;
        b_r   <= rhs;
        q_r   <= '0;
        neg_r <= 1'b0;
      end else begin
        a_r   <= '0;
        b_r   <= rhs_mag;
        q_r   <= lhs_mag;
        neg_r <= (op == sbc_pkg::MD_DIVS) ? (lhs[W-1] ^ rhs[W-1])
                                          : (is_signed && lhs[W-1]);
      end
    end else if (busy_r) begin
      if (op_r == sbc_pkg::MD_MUL) begin
        if (b_r[0]) begin
          rem_r <= {1'b0, rem_r[W-1:0] + a_r};
        end
        a_r <= {a_r[W-2:0], 1'b0};
        b_r <= {1'b0, b_r[W-1:1]};
      end else begin
        rem_r <= ge ? diff[W:0] : shifted;
        q_r   <= {q_r[W-2:0], ge};
      end
    end
  end

  // Final result selection with sign fix.
  always_comb begin
    unique case (op_r)
      sbc_pkg::MD_MUL:  result = rem_r[W-1:0];
      sbc_pkg::MD_DIVU: result = q_r;
      sbc_pkg::MD_MODU: result = rem_r[W-1:0];
      sbc_pkg::MD_DIVS: result = neg_r ? (~q_r + 1'b1) : q_r;
      sbc_pkg::MD_MODS: result = neg_r ? (~rem_r[W-1:0] + 1'b1) : rem_r[W-1:0];
      default:          result = rem_r[W-1:0];
    endcase
  end

  assign done = done_r;

endmodule
`default_nettype wire

FILE: rtl/sbc_dp.sv
// ---------------------------------------------------------------------------
// Stack core datapath
// Holds the instruction, top register, stack pointer, stack memory, the
// multiply/divide unit and the result and output registers.
// ---------------------------------------------------------------------------
`default_nettype none
module sbc_dp #(
  parameter int unsigned STACK_DEPTH = 1024,
  parameter int unsigned PC_BITS     = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sbc_pkg::dp_cmd_t            cmd,
  output sbc_pkg::dp_sts_t                 sts,
  input  wire logic [sbc_pkg::CMD_W-1:0]   in_cmd,
  input  wire logic [sbc_pkg::WORD_W-1:0]  in_arg,
  input  wire logic [sbc_pkg::PC_W-1:0]    in_pc,
  output logic      [sbc_pkg::PC_W-1:0]    out_next_pc,
  output logic                             out_done_res,
  output logic      [sbc_pkg::WORD_W-1:0]  out_value,
  output logic      [sbc_pkg::STAT_W-1:0]  out_status
);

  localparam int unsigned W     = sbc_pkg::WORD_W;
  localparam int unsigned PW    = sbc_pkg::PC_W;
  localparam int unsigned AW    = $clog2(STACK_DEPTH);
  localparam int unsigned SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned NPC_W = (PC_BITS < PW) ? PC_BITS : PW;
  localparam logic [PW-1:0] PC_MASK = PW'((33'd1 << NPC_W) - 33'd1);
  localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);
  localparam logic [SP_W-1:0] SP_ONE  = SP_W'(1);

  // Instruction and architectural state.
  sbc_pkg::opcode_t  cmd_r;
  logic [W-1:0]      arg_r;
  logic [PW-1:0]     pc_r;
  logic [W-1:0]      top_r;
  logic [SP_W-1:0]   sp_r;

  // Result held for the output register.
  logic [PW-1:0]     res_pc_r;
  logic              res_done_r;
  logic [W-1:0]      res_val_r;
  sbc_pkg::status_t  res_st_r;

  // Computed next values.
  logic [W-1:0]      top_n;
  logic [SP_W-1:0]   sp_n;
  logic [PW-1:0]     npc_n;
  logic              done_n;
  logic [W-1:0]      val_n;
  sbc_pkg::status_t  st_n;
  logic              need_read;
  logic              is_md;
  sbc_pkg::md_op_t   md_op;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [W-1:0]      word;
  logic              md_done;
  logic [W-1:0]      md_res;

  logic [PW-1:0]     pc1;
  logic [PW-1:0]     pcj;
  logic              sp_full;
  logic              sp_zero;
  logic              arg_gt_sp;
  logic              arg_zero;
  logic [SP_W-1:0]   idx;
  logic [SP_W-1:0]   sp_m1;
  logic [5:0]        sh;
  logic [W-1:0]      alu_res;

  assign pc1       = (pc_r + 16'd1) & PC_MASK;
  assign pcj       = (pc_r + arg_r[PW-1:0]) & PC_MASK;
  assign sp_full   = (sp_r == SP_FULL);
  assign sp_zero   = (sp_r == '0);
  assign arg_gt_sp = (arg_r > W'(sp_r));
  assign arg_zero  = (arg_r == '0);
  assign idx       = sp_r - arg_r[SP_W-1:0];
  assign sp_m1     = sp_r - SP_ONE;
  assign sh        = top_r[5:0];

  // Two-operand ALU: left operand from memory, right from the top register.
  always_comb begin
    unique case (cmd_r)
      sbc_pkg::OP_ADD: alu_res = word + top_r;
      sbc_pkg::OP_SUB: alu_res = word - top_r;
      sbc_pkg::OP_AND: alu_res = word & top_r;
      sbc_pkg::OP_OR:  alu_res = word | top_r;
      sbc_pkg::OP_XOR: alu_res = word ^ top_r;
      sbc_pkg::OP_SHL: alu_res = word << sh;
      sbc_pkg::OP_SHR: alu_res = word >> sh;
      sbc_pkg::OP_SAR: alu_res = W'($signed(word) >>> sh);
      sbc_pkg::OP_EQU: alu_res = W'(word == top_r);
      sbc_pkg::OP_NEQ: alu_res = W'(word != top_r);
      sbc_pkg::OP_LES: alu_res = W'($signed(word) <  $signed(top_r));
      sbc_pkg::OP_LEQ: alu_res = W'($signed(word) <= $signed(top_r));
      sbc_pkg::OP_GTR: alu_res = W'($signed(word) >  $signed(top_r));
      sbc_pkg::OP_GEQ: alu_res = W'($signed(word) >= $signed(top_r));
      sbc_pkg::OP_BEL: alu_res = W'(word <  top_r);
      sbc_pkg::OP_BEQ: alu_res = W'(word <= top_r);
      sbc_pkg::OP_ABV: alu_res = W'(word >  top_r);
      default:         alu_res = W'(word >= top_r);
    endcase
  end

  // Instruction decode, checks and next state.
  always_comb begin
    st_n      = sbc_pkg::ST_OK;
    top_n     = top_r;
    sp_n      = sp_r;
    npc_n     = pc1;
    done_n    = 1'b0;
    val_n     = top_r;
    need_read = 1'b0;
    is_md     = 1'b0;
    md_op     = sbc_pkg::MD_MUL;
    we        = 1'b0;
    waddr     = sp_r[AW-1:0];
    raddr     = sp_m1[AW-1:0];
    unique case (cmd_r)
      sbc_pkg::OP_ENDL: begin
        done_n = 1'b1;
        val_n  = arg_r;
        npc_n  = pc_r;
      end
      sbc_pkg::OP_ENDV: begin
        done_n = 1'b1;
        npc_n  = pc_r;
      end
      sbc_pkg::OP_PUSHL, sbc_pkg::OP_CALL, sbc_pkg::OP_OPSIZE,
      sbc_pkg::OP_INSSIZE: begin
        if (sp_full) begin
          st_n = sbc_pkg::ST_OVER;
        end else begin
          we   = 1'b1;
          sp_n = sp_r + SP_ONE;
          priority case (cmd_r)
            sbc_pkg::OP_PUSHL:  top_n = arg_r;
            sbc_pkg::OP_OPSIZE: top_n = sbc_pkg::OPERAND_BYTES;
            sbc_pkg::OP_INSSIZE: top_n = sbc_pkg::INSTR_BYTES;
            default: begin
              top_n = W'(pc1);
              npc_n = pcj;
            end
          endcase
        end
      end
      sbc_pkg::OP_PUSHV: begin
        if (sp_full) begin
          st_n = sbc_pkg::ST_OVER;
        end else if (arg_gt_sp) begin
          st_n = sbc_pkg::ST_UNDER;
        end else begin
          we        = 1'b1;
          sp_n      = sp_r + SP_ONE;
          need_read = !arg_zero;
          raddr     = idx[AW-1:0];
          top_n     = arg_zero ? top_r : word;
        end
      end
      sbc_pkg::OP_POP: begin
        if (arg_gt_sp) begin
          st_n = sbc_pkg::ST_UNDER;
        end else if (!arg_zero) begin
          sp_n      = idx;
          need_read = 1'b1;
          raddr     = idx[AW-1:0];
          top_n     = word;
        end
      end
      sbc_pkg::OP_XCHG: begin
        if (!arg_zero) begin
          if (arg_gt_sp) begin
            st_n = sbc_pkg::ST_UNDER;
          end else begin
            need_read = 1'b1;
            raddr     = idx[AW-1:0];
            we        = 1'b1;
            waddr     = idx[AW-1:0];
            top_n     = word;
          end
        end
      end
      sbc_pkg::OP_NEG:  top_n = ~top_r + 1'b1;
      sbc_pkg::OP_NOT:  top_n = ~top_r;
      sbc_pkg::OP_JMP:  npc_n = pcj;
      sbc_pkg::OP_RETL: begin
        npc_n = top_r[PW-1:0] & PC_MASK;
        top_n = arg_r;
      end
      default: begin
        if (cmd_r == sbc_pkg::OP_DUMMY || cmd_r > sbc_pkg::OP_INSSIZE) begin
          st_n = sbc_pkg::ST_ILLEGAL;
        end else if (sp_zero) begin
          st_n = sbc_pkg::ST_UNDER;
        end else if ((cmd_r == sbc_pkg::OP_DIV || cmd_r == sbc_pkg::OP_IDIV ||
                      cmd_r == sbc_pkg::OP_MOD || cmd_r == sbc_pkg::OP_IMOD) &&
                     (top_r == '0)) begin
          st_n = sbc_pkg::ST_DIVZ;
        end else begin
          need_read = 1'b1;
          sp_n      = sp_m1;
          priority case (cmd_r)
            sbc_pkg::OP_JZ:   npc_n = (word != '0) ? pc1 : pcj;
            sbc_pkg::OP_JNZ:  npc_n = (word == '0) ? pc1 : pcj;
            sbc_pkg::OP_RET: begin
              npc_n = top_r[PW-1:0] & PC_MASK;
              top_n = word;
            end
            sbc_pkg::OP_RETV: npc_n = word[PW-1:0] & PC_MASK;
            sbc_pkg::OP_MUL: begin
              is_md = 1'b1;
              md_op = sbc_pkg::MD_MUL;
            end
            sbc_pkg::OP_DIV: begin
              is_md = 1'b1;
              md_op = sbc_pkg::MD_DIVU;
            end
            sbc_pkg::OP_IDIV: begin
              is_md = 1'b1;
              md_op = sbc_pkg::MD_DIVS;
            end
            sbc_pkg::OP_MOD: begin
              is_md = 1'b1;
              md_op = sbc_pkg::MD_MODU;
            end
            sbc_pkg::OP_IMOD: begin
              is_md = 1'b1;
              md_op = sbc_pkg::MD_MODS;
            end
            default: top_n = alu_res;
          endcase
        end
      end
    endcase
    // A failed check leaves the state alone and repeats the instruction.
    if (st_n != sbc_pkg::ST_OK) begin
      npc_n  = pc_r;
      done_n = 1'b0;
      val_n  = top_r;
    end else if (!done_n) begin
      val_n = top_n;
    end
  end

  assign sts.need_read = need_read;
  assign sts.is_md     = is_md;
  assign sts.md_done   = md_done;

  // Stack memory.
  sbc_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we && cmd.exec && (st_n == sbc_pkg::ST_OK)),
    .waddr (waddr),
    .wdata (top_r),
    .raddr (raddr),
    .rdata (word)
  );

  // Shared multiply/divide unit.
  sbc_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.md_start),
    .op     (md_op),
    .lhs    (word),
    .rhs    (top_r),
    .done   (md_done),
    .result (md_res)
  );

  // Architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
      sp_r  <= '0;
    end else if (cmd.exec && (st_n == sbc_pkg::ST_OK)) begin
      top_r <= top_n;
      sp_r  <= sp_n;
    end else if (cmd.md_fin) begin
      top_r <= md_res;
      sp_r  <= sp_n;
    end
  end

  // Instruction, result and output payload registers.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cmd_r <= in_cmd;
      arg_r <= in_arg;
      pc_r  <= in_pc;
    end
    if (cmd.exec) begin
      res_pc_r   <= npc_n;
      res_done_r <= done_n;
      res_val_r  <= val_n;
      res_st_r   <= st_n;
    end else if (cmd.md_fin) begin
      res_pc_r   <= npc_n;
      res_done_r <= 1'b0;
      res_val_r  <= md_res;
      res_st_r   <= sbc_pkg::ST_OK;
    end
    if (cmd.load_out) begin
      out_next_pc  <= res_pc_r;
      out_done_res <= res_done_r;
      out_value    <= res_val_r;
      out_status   <= res_st_r;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sbc_ctrl.sv
// ---------------------------------------------------------------------------
// Stack core controller
// Sequences decode, memory read, execute and multiply/divide wait, and
// owns the handshakes of both channels.
// ---------------------------------------------------------------------------
`default_nettype none
module sbc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output sbc_pkg::dp_cmd_t      cmd,
  input  wire sbc_pkg::dp_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_EXEC, S_WAIT, S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.take     = in_valid && in_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.need_read) begin
          state_nxt = S_EXEC;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_EXEC: begin
        if (sts.is_md) begin
          cmd.md_start = 1'b1;
          state_nxt    = S_WAIT;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_WAIT: begin
        if (sts.md_done) begin
          cmd.md_fin = 1'b1;
          state_nxt  = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // State and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // An accepted instruction is decoded in the next cycle.
  a_take_decode: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> (state_r == S_DECODE))
    else $error("accepted instruction not decoded");

  // A loaded result is offered on the next cycle.
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not offered");

  // The multiply/divide unit only finishes while the controller waits for it.
  a_md_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.md_done |-> (state_r == S_WAIT))
    else $error("multiply/divide finished outside wait");

endmodule
`default_nettype wire
